>>> design/lav_pkg.sv
// Shared types, constants and rounding helpers for the look-at view matrix block.
package lav_pkg;

    localparam int Q_FRAC    = 16;
    localparam int VW        = 51;              // component width into the normalizer
    localparam int CW        = 31;              // reduced magnitude width
    localparam int SW        = 5;               // reduction shift width
    localparam int UW        = 18;              // unit component width
    localparam int RW        = 19;              // matrix row element width
    localparam int ISQ_STEPS = 32;              // root bits, one per stage
    localparam int QB        = 17;              // quotient bits, one per stage
    localparam int DW        = CW + Q_FRAC + 1; // divider remainder width

    localparam logic signed [31:0] Q_ONE = 32'sd65536;

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_FWD   = 2'd2;

    localparam logic [1:0] REG_UP_X = 2'd0;
    localparam logic [1:0] REG_UP_Y = 2'd1;
    localparam logic [1:0] REG_UP_Z = 2'd2;

    localparam logic signed [31:0] UP_X_RST = 32'sd0;
    localparam logic signed [31:0] UP_Y_RST = Q_ONE;
    localparam logic signed [31:0] UP_Z_RST = 32'sd0;

    typedef logic signed [31:0] q16_t;

    typedef struct packed {
        q16_t eye_x;
        q16_t eye_y;
        q16_t eye_z;
        q16_t target_x;
        q16_t target_y;
        q16_t target_z;
    } lav_req_t;

    typedef struct packed {
        logic [1:0] row_index;
        q16_t       col0;
        q16_t       col1;
        q16_t       col2;
        q16_t       col3;
        logic       degenerate;
        logic       last_row;
    } lav_row_t;

    typedef logic [2:0][VW-1:0] lav_vec_t;
    typedef logic [2:0][UW-1:0] lav_unit_t;

    // context that rides along with a vector through the normalizer
    typedef struct packed {
        logic [2:0][31:0] eye;
        lav_unit_t        f;
        logic             degen;
    } lav_side_t;

    // normalizer internal context: reduced magnitudes, signs, zero flag
    typedef struct packed {
        logic [2:0][CW-1:0] c;
        logic [2:0]         neg;
        logic               zero;
        lav_side_t          side;
    } lav_nside_t;

    // divide by 2^16, rounding half away from zero
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
        logic [63:0] m;
        logic [63:0] r;
        m = x[63] ? (~x + 64'd1) : x;
        r = (m + 64'd32768) >> Q_FRAC;
        return x[63] ? $signed(~r + 64'd1) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

>>> design/lav_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module lav_isqrt
    import lav_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] x,
    input  lav_nside_t  in_side,
    output logic        out_valid,
    output logic [31:0] root,
    output lav_nside_t  out_side
);

    logic              valid_reg [ISQ_STEPS];
    logic [33:0]       rem_reg   [ISQ_STEPS];
    logic [31:0]       root_reg  [ISQ_STEPS];
    logic [63:0]       x_reg     [ISQ_STEPS];
    lav_nside_t        side_reg  [ISQ_STEPS];

    logic [33:0]       rem_next  [ISQ_STEPS];
    logic [31:0]       root_next [ISQ_STEPS];
    logic [63:0]       x_next    [ISQ_STEPS];

    logic [33:0]       rem_in;
    logic [31:0]       root_in;
    logic [63:0]       x_in;
    logic [35:0]       bring;
    logic [35:0]       trial;

    always_comb
    begin
        rem_in  = '0;
        root_in = '0;
        x_in    = '0;
        bring   = '0;
        trial   = '0;
        for (int k = 0; k < ISQ_STEPS; k++)
        begin
            if (k == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                x_in    = x;
            end
            else
            begin
                rem_in  = rem_reg[k-1];
                root_in = root_reg[k-1];
                x_in    = x_reg[k-1];
            end
            bring = {rem_in, x_in[63:62]};
            trial = {2'b00, root_in, 2'b01};
            if (bring >= trial)
            begin
                rem_next[k]  = 34'(bring - trial);
                root_next[k] = {root_in[30:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = bring[33:0];
                root_next[k] = {root_in[30:0], 1'b0};
            end
            x_next[k] = {x_in[61:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ISQ_STEPS; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < ISQ_STEPS; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 1; k < ISQ_STEPS; k++)
                side_reg[k] <= side_reg[k-1];
            for (int k = 0; k < ISQ_STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                x_reg[k]    <= x_next[k];
            end
        end
    end

    assign out_valid = valid_reg[ISQ_STEPS-1];
    assign root      = root_reg[ISQ_STEPS-1];
    assign out_side  = side_reg[ISQ_STEPS-1];

endmodule

>>> design/lav_div.sv
// Pipelined three-lane restoring divider: (c * 2^16) / len, one quotient bit per stage.
module lav_div
    import lav_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [31:0]          len,
    input  lav_nside_t           in_side,
    output logic                 out_valid,
    output logic [2:0][QB-1:0]   quo,
    output lav_nside_t           out_side
);

    logic                 valid_reg [QB];
    logic [2:0][DW-1:0]   rem_reg   [QB];
    logic [2:0][QB-1:0]   q_reg     [QB];
    logic [31:0]          len_reg   [QB];
    lav_nside_t           side_reg  [QB];

    logic [2:0][DW-1:0]   rem_next  [QB];
    logic [2:0][QB-1:0]   q_next    [QB];

    logic [2:0][DW-1:0]   rem_in;
    logic [2:0][QB-1:0]   q_in;
    logic [31:0]          len_in;
    logic [DW-1:0]        dv;

    always_comb
    begin
        rem_in = '0;
        q_in   = '0;
        len_in = '0;
        dv     = '0;
        for (int k = 0; k < QB; k++)
        begin
            if (k == 0)
            begin
                for (int i = 0; i < 3; i++)
                    rem_in[i] = {1'b0, in_side.c[i], {Q_FRAC{1'b0}}};
                q_in   = '0;
                len_in = len;
            end
            else
            begin
                rem_in = rem_reg[k-1];
                q_in   = q_reg[k-1];
                len_in = len_reg[k-1];
            end
            dv = {{(DW-32){1'b0}}, len_in} << (QB - 1 - k);
            for (int i = 0; i < 3; i++)
            begin
                if (rem_in[i] >= dv)
                begin
                    rem_next[k][i] = rem_in[i] - dv;
                    q_next[k][i]   = q_in[i] | (QB'(1) << (QB - 1 - k));
                end
                else
                begin
                    rem_next[k][i] = rem_in[i];
                    q_next[k][i]   = q_in[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QB; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < QB; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            len_reg[0]  <= len;
            for (int k = 1; k < QB; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                len_reg[k]  <= len_reg[k-1];
            end
            for (int k = 0; k < QB; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign out_valid = valid_reg[QB-1];
    assign quo       = q_reg[QB-1];
    assign out_side  = side_reg[QB-1];

endmodule

>>> design/lav_norm.sv
// Vector normalizer: range reduction, sum of squares, square root, per-lane divide.
module lav_norm
    import lav_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  lav_vec_t  vec,
    input  lav_side_t in_side,
    output logic      out_valid,
    output lav_unit_t unit,
    output logic      zero,
    output lav_side_t out_side
);

    // s0: magnitudes and sign
    logic                v0_reg;
    logic [2:0][VW-1:0]  m0_reg;
    logic [2:0]          neg0_reg;
    logic [VW-1:0]       or0_reg;
    lav_side_t           side0_reg;
    logic [2:0][VW-1:0]  m0_next;
    logic [2:0]          neg0_next;

    // s1: reduction shift
    logic                v1_reg;
    logic [2:0][VW-1:0]  m1_reg;
    logic [2:0]          neg1_reg;
    logic                zero1_reg;
    logic [SW-1:0]       sh1_reg;
    lav_side_t           side1_reg;
    logic [SW-1:0]       sh1_next;

    // s2: reduced components
    logic                v2_reg;
    lav_nside_t          ns2_reg;
    logic [2:0][CW-1:0]  c2_next;

    // s3: squares
    logic                v3_reg;
    lav_nside_t          ns3_reg;
    logic [2:0][2*CW-1:0] sq3_reg;

    // s4: sum of squares
    logic                v4_reg;
    lav_nside_t          ns4_reg;
    logic [63:0]         sum4_reg;

    logic                isq_valid;
    logic [31:0]         isq_root;
    lav_nside_t          isq_side;
    logic                div_valid;
    logic [2:0][QB-1:0]  div_quo;
    lav_nside_t          div_side;

    // output stage
    logic                vo_reg;
    lav_unit_t           unit_reg;
    logic                zero_reg;
    lav_side_t           side_o_reg;
    lav_unit_t           unit_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg0_next[i] = vec[i][VW-1];
            m0_next[i]   = vec[i][VW-1] ? (~vec[i] + 1'b1) : vec[i];
        end
    end

    always_comb
    begin
        sh1_next = '0;
        for (int k = CW; k < VW; k++)
            if (or0_reg[k])
                sh1_next = SW'(k - CW + 1);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            c2_next[i] = CW'(m1_reg[i] >> sh1_reg);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (div_side.neg[i])
                unit_next[i] = ~{1'b0, div_quo[i]} + 1'b1;
            else
                unit_next[i] = {1'b0, div_quo[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vo_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg    <= m0_next;
            neg0_reg  <= neg0_next;
            or0_reg   <= m0_next[0] | m0_next[1] | m0_next[2];
            side0_reg <= in_side;

            m1_reg    <= m0_reg;
            neg1_reg  <= neg0_reg;
            zero1_reg <= (or0_reg == '0);
            sh1_reg   <= sh1_next;
            side1_reg <= side0_reg;

            ns2_reg.c    <= c2_next;
            ns2_reg.neg  <= neg1_reg;
            ns2_reg.zero <= zero1_reg;
            ns2_reg.side <= side1_reg;

            ns3_reg <= ns2_reg;
            for (int i = 0; i < 3; i++)
                sq3_reg[i] <= ns2_reg.c[i] * ns2_reg.c[i];

            ns4_reg  <= ns3_reg;
            sum4_reg <= 64'(sq3_reg[0]) + 64'(sq3_reg[1]) + 64'(sq3_reg[2]);

            unit_reg   <= unit_next;
            zero_reg   <= div_side.zero;
            side_o_reg <= div_side.side;
        end
    end

    lav_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .x         (sum4_reg),
        .in_side   (ns4_reg),
        .out_valid (isq_valid),
        .root      (isq_root),
        .out_side  (isq_side)
    );

    lav_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (isq_valid),
        .len       (isq_root),
        .in_side   (isq_side),
        .out_valid (div_valid),
        .quo       (div_quo),
        .out_side  (div_side)
    );

    assign out_valid = vo_reg;
    assign unit      = unit_reg;
    assign zero      = zero_reg;
    assign out_side  = side_o_reg;

endmodule

>>> design/lav_tail.sv
// Row assembly: up row from R x F, identity on degenerate, translations from the eye.
module lav_tail
    import lav_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  lav_unit_t             r,
    input  lav_unit_t             f,
    input  logic [2:0][31:0]      eye,
    input  logic                  degen,
    output logic                  out_valid,
    output logic [2:0][2:0][31:0] rows,
    output logic [2:0][31:0]      tr,
    output logic                  out_degen
);

    // t0: R x F partial products
    logic                     v0_reg;
    logic signed [2*UW-1:0]   p0_reg [6];
    lav_unit_t                r0_reg;
    lav_unit_t                f0_reg;
    logic [2:0][31:0]         eye0_reg;
    logic                     dg0_reg;

    // t1: matrix rows
    logic                     v1_reg;
    logic signed [RW-1:0]     row1_reg [3][3];
    logic signed [RW-1:0]     row1_next [3][3];
    logic signed [2*UW:0]     ur;
    logic signed [63:0]       ur_rnd;
    logic [2:0][31:0]         eye1_reg;
    logic                     dg1_reg;

    // t2: row times eye products
    logic                     v2_reg;
    logic signed [RW+31:0]    pe2_reg [3][3];
    logic signed [RW-1:0]     row2_reg [3][3];
    logic                     dg2_reg;

    // t3: dot products
    logic                     v3_reg;
    logic signed [RW+33:0]    acc3_reg [3];
    logic signed [RW-1:0]     row3_reg [3][3];
    logic                     dg3_reg;

    // t4: output
    logic                     v4_reg;
    logic [2:0][2:0][31:0]    rows4_reg;
    logic [2:0][31:0]         tr4_reg;
    logic                     dg4_reg;

    always_comb
    begin
        ur     = '0;
        ur_rnd = '0;
        for (int i = 0; i < 3; i++)
        begin
            ur     = (2*UW+1)'(p0_reg[2*i]) - (2*UW+1)'(p0_reg[2*i+1]);
            ur_rnd = rnd16(64'(ur));
            if (dg0_reg)
            begin
                for (int k = 0; k < 3; k++)
                    row1_next[k][i] = (i == k) ? RW'(Q_ONE) : '0;
            end
            else
            begin
                row1_next[0][i] = RW'($signed(r0_reg[i]));
                row1_next[1][i] = ur_rnd[RW-1:0];
                row1_next[2][i] = -RW'($signed(f0_reg[i]));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg[0] <= $signed(r[1]) * $signed(f[2]);
            p0_reg[1] <= $signed(r[2]) * $signed(f[1]);
            p0_reg[2] <= $signed(r[2]) * $signed(f[0]);
            p0_reg[3] <= $signed(r[0]) * $signed(f[2]);
            p0_reg[4] <= $signed(r[0]) * $signed(f[1]);
            p0_reg[5] <= $signed(r[1]) * $signed(f[0]);
            r0_reg    <= r;
            f0_reg    <= f;
            eye0_reg  <= eye;
            dg0_reg   <= degen;

            row1_reg <= row1_next;
            eye1_reg <= eye0_reg;
            dg1_reg  <= dg0_reg;

            for (int k = 0; k < 3; k++)
                for (int i = 0; i < 3; i++)
                    pe2_reg[k][i] <= row1_reg[k][i] * $signed(eye1_reg[i]);
            row2_reg <= row1_reg;
            dg2_reg  <= dg1_reg;

            for (int k = 0; k < 3; k++)
                acc3_reg[k] <= (RW+34)'(pe2_reg[k][0]) + (RW+34)'(pe2_reg[k][1])
                             + (RW+34)'(pe2_reg[k][2]);
            row3_reg <= row2_reg;
            dg3_reg  <= dg2_reg;

            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                    rows4_reg[k][i] <= 32'(row3_reg[k][i]);
                tr4_reg[k] <= dg3_reg ? 32'd0 : sat32(-rnd16(64'(acc3_reg[k])));
            end
            dg4_reg <= dg3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign rows      = rows4_reg;
    assign tr        = tr4_reg;
    assign out_degen = dg4_reg;

endmodule

>>> design/look_at_view_matrix.sv
// Look-at view matrix generator, top level.
//
//   channel  dir  handshake            payload
//   cam      in   cam_valid/cam_ready  lav_req_t: eye and target, Q16.16
//   row      out  row_valid/row_ready  lav_row_t: one matrix row per transfer
//   apb      in   psel/penable/pwrite  up_x, up_y, up_z at 0x0, 0x4, 0x8
//
// Each request leaves as three row results through the output serializer,
// which sets the sustained request rate. From accept to the first row the
// path runs through two 55-stage normalizers (32 root stages, 17 divide
// stages each), input, cross product and row assembly stages.
// Reset clears all valid bits and loads the up vector with (0, 1.0, 0).
// A row stall freezes the pipe once its last stage is full; nothing is dropped.
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cam_valid,
    output logic        cam_ready,
    input  lav_req_t    cam,

    output logic        row_valid,
    input  logic        row_ready,
    output lav_row_t    row,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration ----------------
    logic signed [31:0] up_x_reg;
    logic signed [31:0] up_y_reg;
    logic signed [31:0] up_z_reg;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg <= UP_X_RST;
            up_y_reg <= UP_Y_RST;
            up_z_reg <= UP_Z_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_UP_X: up_x_reg <= pwdata;
                REG_UP_Y: up_y_reg <= pwdata;
                REG_UP_Z: up_z_reg <= pwdata;
                default:  ;   // unmapped offset, write dropped
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_UP_X: prdata = up_x_reg;
            REG_UP_Y: prdata = up_y_reg;
            REG_UP_Z: prdata = up_z_reg;
            default:  prdata = '0;
        endcase
    end

    // ---------------- pipeline advance ----------------
    // One global enable: the pipe moves whenever its last stage is empty
    // or the serializer can take that stage's matrix.
    logic adv;
    logic tail_valid;
    logic ser_valid_reg;
    logic row_take;
    logic row_done;
    logic ser_load;
    logic [1:0] cnt_reg;

    assign row_take  = row_valid && row_ready;
    assign row_done  = row_take && (cnt_reg == ROW_FWD);
    assign adv       = !tail_valid || !ser_valid_reg || row_done;
    assign ser_load  = tail_valid && (!ser_valid_reg || row_done);
    assign cam_ready = adv;

    // ---------------- input stage: eye and target - eye ----------------
    logic               in_v_reg;
    logic [2:0][31:0]   eye_in_reg;
    logic [2:0][32:0]   d_reg;
    lav_vec_t           n1_vec;
    lav_side_t          n1_side_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (adv)
            in_v_reg <= cam_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            eye_in_reg[0] <= cam.eye_x;
            eye_in_reg[1] <= cam.eye_y;
            eye_in_reg[2] <= cam.eye_z;
            d_reg[0] <= 33'(cam.target_x) - 33'(cam.eye_x);
            d_reg[1] <= 33'(cam.target_y) - 33'(cam.eye_y);
            d_reg[2] <= 33'(cam.target_z) - 33'(cam.eye_z);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n1_vec[i] = VW'($signed(d_reg[i]));
        n1_side_in.eye   = eye_in_reg;
        n1_side_in.f     = '0;
        n1_side_in.degen = 1'b0;
    end

    // ---------------- forward normalize ----------------
    logic      n1_valid;
    lav_unit_t n1_unit;
    logic      n1_zero;
    lav_side_t n1_side;

    lav_norm u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_v_reg),
        .vec       (n1_vec),
        .in_side   (n1_side_in),
        .out_valid (n1_valid),
        .unit      (n1_unit),
        .zero      (n1_zero),
        .out_side  (n1_side)
    );

    // ---------------- F x up ----------------
    // Exact Q18.32 terms; user must keep up static while requests are in flight.
    logic                 x0_v_reg;
    logic signed [49:0]   xp_reg [6];
    lav_side_t            x0_side_reg;
    logic                 x1_v_reg;
    lav_vec_t             x1_vec_reg;
    lav_side_t            x1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x0_v_reg <= 1'b0;
            x1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            x0_v_reg <= n1_valid;
            x1_v_reg <= x0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xp_reg[0] <= $signed(n1_unit[1]) * up_z_reg;
            xp_reg[1] <= $signed(n1_unit[2]) * up_y_reg;
            xp_reg[2] <= $signed(n1_unit[2]) * up_x_reg;
            xp_reg[3] <= $signed(n1_unit[0]) * up_z_reg;
            xp_reg[4] <= $signed(n1_unit[0]) * up_y_reg;
            xp_reg[5] <= $signed(n1_unit[1]) * up_x_reg;
            x0_side_reg.eye   <= n1_side.eye;
            x0_side_reg.f     <= n1_unit;
            x0_side_reg.degen <= n1_zero;

            for (int i = 0; i < 3; i++)
                x1_vec_reg[i] <= VW'(xp_reg[2*i]) - VW'(xp_reg[2*i+1]);
            x1_side_reg <= x0_side_reg;
        end
    end

    // ---------------- right normalize ----------------
    logic      n2_valid;
    lav_unit_t n2_unit;
    logic      n2_zero;
    lav_side_t n2_side;

    lav_norm u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (x1_v_reg),
        .vec       (x1_vec_reg),
        .in_side   (x1_side_reg),
        .out_valid (n2_valid),
        .unit      (n2_unit),
        .zero      (n2_zero),
        .out_side  (n2_side)
    );

    // ---------------- rows and translations ----------------
    logic [2:0][2:0][31:0] tail_rows;
    logic [2:0][31:0]      tail_tr;
    logic                  tail_degen;

    lav_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (n2_valid),
        .r         (n2_unit),
        .f         (n2_side.f),
        .eye       (n2_side.eye),
        .degen     (n2_side.degen || n2_zero),
        .out_valid (tail_valid),
        .rows      (tail_rows),
        .tr        (tail_tr),
        .out_degen (tail_degen)
    );

    // ---------------- output serializer ----------------
    // Holds one finished matrix and hands out its rows in order.
    logic [2:0][2:0][31:0] ser_rows_reg;
    logic [2:0][31:0]      ser_tr_reg;
    logic                  ser_degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            cnt_reg       <= ROW_RIGHT;
        end
        else
        begin
            priority if (ser_load)
            begin
                ser_valid_reg <= 1'b1;
                cnt_reg       <= ROW_RIGHT;
            end
            else if (row_done)
            begin
                ser_valid_reg <= 1'b0;
                cnt_reg       <= ROW_RIGHT;
            end
            else if (row_take)
                cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            ser_rows_reg  <= tail_rows;
            ser_tr_reg    <= tail_tr;
            ser_degen_reg <= tail_degen;
        end
    end

    assign row_valid = ser_valid_reg;

    always_comb
    begin
        row.row_index  = cnt_reg;
        row.col0       = ser_rows_reg[cnt_reg][0];
        row.col1       = ser_rows_reg[cnt_reg][1];
        row.col2       = ser_rows_reg[cnt_reg][2];
        row.col3       = ser_tr_reg[cnt_reg];
        row.degenerate = ser_degen_reg;
        row.last_row   = (cnt_reg == ROW_FWD);
    end

endmodule

>>> design/lav_checker.sv
// Port-level checker for the look-at view matrix block, with its bind.
module lav_checker
    import lav_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     row_valid,
    input logic     row_ready,
    input lav_row_t row
);

    // rows of one matrix follow back to back in index order
    a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_ready && !row.last_row
        |=> row_valid && (row.row_index == $past(row.row_index) + 2'd1))
        else $error("row sequence broken");

    // the degenerate flag is the same on all rows of a matrix
    a_degen_hold: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row_ready && !row.last_row
        |=> row.degenerate == $past(row.degenerate))
        else $error("degenerate flag changed inside a matrix");

    // identity output carries no translation
    a_degen_tr: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && row.degenerate |-> row.col3 == 32'sd0)
        else $error("translation nonzero on degenerate matrix");

    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid && !row_ready |=> row_valid && $stable(row))
        else $error("stalled row changed");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row       (row)
);
